// ----- sv/jddm_pkg.sv -----
// Shared constants and types for the joystick differential drive mixer.
// No dependencies; imported by every module of the block.
package jddm_pkg;

   // Fixed field widths
   localparam int AXIS_W  = 8;
   localparam int SPEED_W = 13;
   localparam int DZ_W    = 7;
   localparam int SUM_W   = 16;   // ax^2 + ay^2 for 8-bit magnitudes
   localparam int ROOT_W  = 8;

   // Default scales
   localparam int IN_FULL_SCALE_DEF  = 100;
   localparam int OUT_FULL_SCALE_DEF = 4095;

   localparam logic [DZ_W-1:0]    DEADZONE_RESET = 7'd2;
   localparam logic [SPEED_W-1:0] SPEED_MAX      = 13'd8191;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_DEADZONE = 1'b0;

   // Handshake status of a multi-cycle arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;   // one-cycle pulse, result valid in the same cycle
   } unit_status_type;

endpackage

// ----- sv/jddm_isqrt.sv -----
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on jddm_pkg for widths and the unit status struct.
module jddm_isqrt import jddm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SUM_W-1:0]      radicand,
   output logic [ROOT_W-1:0]     root,
   output unit_status_type       status
);

   localparam int REM_W  = ROOT_W + 3;
   localparam int STEPS  = SUM_W / 2;
   localparam int CNT_W  = $clog2(STEPS + 1);

   logic [SUM_W-1:0]  val_ff,  val_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;

   // One root bit per step: compare shifted remainder with 4*root+1
   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], val_ff[SUM_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});
      val_in  = val_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[SUM_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- sv/jddm_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on jddm_pkg for the unit status struct.
module jddm_div import jddm_pkg::*; #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_W-1:0]      numer,
   input  logic [DEN_W-1:0]      denom,
   output logic [NUM_W-1:0]      quot,
   output unit_status_type       status
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;   // shifts out dividend, shifts in quotient
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   den_x;
   logic             fits;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      den_x   = {1'b0, denom};
      fits    = (rem_sh >= den_x);
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the difference fits DEN_W bits
         rem_in = fits ? DEN_W'(rem_sh - den_x) : rem_sh[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot        = num_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- sv/joystick_differential_drive_mixer_top.sv -----
// Joystick differential drive mixer: a repeated sample is accepted and dropped; a centered
// stick goes straight to the output state, any other sample passes through the shift-add
// multiplier (squares), the square root, the multiplier (scale), the bit-serial divider,
// the multiplier (steering) and the divider again. One sample is worked at a time: a
// changed sample holds the input until its word moves to the output register; the output register lets
// the next sample in while a word waits. Sync reset: deadzone 2, no history, forward.
module joystick_differential_drive_mixer_top import jddm_pkg::*; #(
   parameter int IN_FULL_SCALE  = IN_FULL_SCALE_DEF,
   parameter int OUT_FULL_SCALE = OUT_FULL_SCALE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // sample channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [AXIS_W-1:0]     req_stick_x,
   input  logic signed [AXIS_W-1:0]     req_stick_y,
   // command channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [SPEED_W-1:0]           rsp_speed_left,
   output logic [SPEED_W-1:0]           rsp_speed_right,
   output logic                         rsp_dir_left,
   output logic                         rsp_dir_right,
   // register port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_W-1:0]        paddr,
   input  logic [CSR_DATA_W-1:0]        pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   localparam int IN_W   = $clog2(IN_FULL_SCALE + 1);
   localparam int OUT_W  = $clog2(OUT_FULL_SCALE + 1);
   localparam int PW     = ROOT_W + OUT_W;                 // full-speed width
   localparam int QW_RAW = PW + IN_W;
   localparam int QW     = (QW_RAW > SUM_W + 1) ? QW_RAW : SUM_W + 1;
   localparam int MW     = (IN_W > ROOT_W) ? IN_W : ROOT_W; // multiplier digit count
   localparam int MCNT_W = $clog2(MW + 1);
   localparam int CW     = (IN_W > AXIS_W) ? IN_W : AXIS_W;
   localparam int SW     = (QW > SPEED_W) ? QW : SPEED_W;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_SQX  = 9'b000000010,
      S_SQY  = 9'b000000100,
      S_ROOT = 9'b000001000,
      S_MUL1 = 9'b000010000,
      S_DIV1 = 9'b000100000,
      S_MUL2 = 9'b001000000,
      S_DIV2 = 9'b010000000,
      S_OUT  = 9'b100000000
   } state_type;

   function automatic logic [AXIS_W-1:0] abs_axis(input logic [AXIS_W-1:0] v);
      return v[AXIS_W-1] ? AXIS_W'(~v + AXIS_W'(1)) : v;
   endfunction

   function automatic logic [SPEED_W-1:0] sat_speed(input logic [QW-1:0] v);
      logic [SW-1:0] e;
      e = SW'(v);
      return (e > SW'(SPEED_MAX)) ? SPEED_MAX : e[SPEED_W-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [DZ_W-1:0]      dz_ff, dz_in;
   logic [AXIS_W-1:0]    last_x_ff, last_x_in;
   logic [AXIS_W-1:0]    last_y_ff, last_y_in;
   logic                 have_last_ff, have_last_in;
   logic                 held_dir_ff, held_dir_in;
   logic [AXIS_W-1:0]    ax_ff, ax_in;
   logic [AXIS_W-1:0]    ay_ff, ay_in;
   logic                 xneg_ff, xneg_in;
   logic [PW-1:0]        full_ff, full_in;
   logic [SPEED_W-1:0]   spd_l_ff, spd_l_in;
   logic [SPEED_W-1:0]   spd_r_ff, spd_r_in;
   // shift-add multiplier
   logic [QW-1:0]        acc_ff, acc_in;
   logic [QW-1:0]        mcand_ff, mcand_in;
   logic [MW-1:0]        mplier_ff, mplier_in;
   logic [MCNT_W-1:0]    mcnt_ff, mcnt_in;
   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0]   rsp_l_ff, rsp_l_in;
   logic [SPEED_W-1:0]   rsp_r_ff, rsp_r_in;
   logic                 rsp_dir_ff, rsp_dir_in;

   logic [AXIS_W-1:0]    rx, ry, req_ax, req_ay;
   logic                 changed, centered;
   logic [QW-1:0]        mul_sum;
   logic                 mul_last;
   logic [IN_W-1:0]      factor;
   logic [QW-1:0]        full_ext;

   logic                 sqrt_start;
   logic [SUM_W-1:0]     sqrt_arg;
   logic [ROOT_W-1:0]    sqrt_root;
   unit_status_type      sqrt_st;
   logic                 div_start;
   logic [QW-1:0]        div_num;
   logic [QW-1:0]        div_quot;
   unit_status_type      div_st;

   // ---- register port ----
   assign pready = 1'b1;
   always_comb begin
      dz_in = dz_ff;
      if (psel && penable && pwrite && paddr[CSR_ADDR_W-1:2] == REG_DEADZONE) begin
         dz_in = pwdata[DZ_W-1:0];
      end
      prdata = '0;
      if (paddr[CSR_ADDR_W-1:2] == REG_DEADZONE) begin
         prdata = CSR_DATA_W'(dz_ff);
      end
   end

   // ---- sample decode ----
   always_comb begin
      rx       = $unsigned(req_stick_x);
      ry       = $unsigned(req_stick_y);
      req_ax   = abs_axis(rx);
      req_ay   = abs_axis(ry);
      changed  = !have_last_ff || rx != last_x_ff || ry != last_y_ff;
      centered = req_ax <= {1'b0, dz_ff} && req_ay <= {1'b0, dz_ff};
   end

   // steering factor saturates at zero past full scale
   always_comb begin
      if (CW'(ax_ff) >= CW'(IN_FULL_SCALE)) begin
         factor = '0;
      end else begin
         factor = IN_W'(CW'(IN_FULL_SCALE) - CW'(ax_ff));
      end
   end

   // one multiplier digit per cycle
   assign mul_sum  = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
   assign mul_last = (mcnt_ff == MCNT_W'(1));
   assign full_ext = QW'(full_ff);

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      have_last_in = have_last_ff;
      held_dir_in  = held_dir_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      xneg_in      = xneg_ff;
      full_in      = full_ff;
      spd_l_in     = spd_l_ff;
      spd_r_in     = spd_r_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      mcnt_in      = mcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_l_in     = rsp_l_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_dir_in   = rsp_dir_ff;
      sqrt_start   = 1'b0;
      sqrt_arg     = mul_sum[SUM_W-1:0];
      div_start    = 1'b0;
      div_num      = mul_sum;
      req_ready    = 1'b0;

      if (state_ff == S_SQX || state_ff == S_SQY || state_ff == S_MUL1 ||
          state_ff == S_MUL2) begin
         acc_in    = mul_sum;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         mcnt_in   = mcnt_ff - MCNT_W'(1);
      end

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && changed) begin
               last_x_in    = rx;
               last_y_in    = ry;
               have_last_in = 1'b1;
               ax_in        = req_ax;
               ay_in        = req_ay;
               xneg_in      = rx[AXIS_W-1];
               if (centered) begin
                  spd_l_in = '0;
                  spd_r_in = '0;
                  state_in = S_OUT;
               end else begin
                  held_dir_in = ry[AXIS_W-1];
                  acc_in      = '0;
                  mcand_in    = QW'(req_ax);
                  mplier_in   = MW'(req_ax);
                  mcnt_in     = MCNT_W'(MW);
                  state_in    = S_SQX;
               end
            end
         end
         S_SQX: begin
            if (mul_last) begin
               // accumulator carries x^2 on into y^2
               mcand_in  = QW'(ay_ff);
               mplier_in = MW'(ay_ff);
               mcnt_in   = MCNT_W'(MW);
               state_in  = S_SQY;
            end
         end
         S_SQY: begin
            if (mul_last) begin
               sqrt_start = 1'b1;
               state_in   = S_ROOT;
            end
         end
         S_ROOT: begin
            if (sqrt_st.done) begin
               acc_in    = '0;
               mcand_in  = QW'(OUT_FULL_SCALE);
               mplier_in = MW'(sqrt_root);
               mcnt_in   = MCNT_W'(MW);
               state_in  = S_MUL1;
            end
         end
         S_MUL1: begin
            if (mul_last) begin
               div_start = 1'b1;
               state_in  = S_DIV1;
            end
         end
         S_DIV1: begin
            if (div_st.done) begin
               full_in   = div_quot[PW-1:0];
               acc_in    = '0;
               mcand_in  = QW'(div_quot[PW-1:0]);
               mplier_in = MW'(factor);
               mcnt_in   = MCNT_W'(MW);
               state_in  = S_MUL2;
            end
         end
         S_MUL2: begin
            if (mul_last) begin
               div_start = 1'b1;
               state_in  = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_st.done) begin
               // inside wheel is on the side x points to
               if (xneg_ff) begin
                  spd_l_in = sat_speed(div_quot);
                  spd_r_in = sat_speed(full_ext);
               end else begin
                  spd_l_in = sat_speed(full_ext);
                  spd_r_in = sat_speed(div_quot);
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_l_in     = spd_l_ff;
               rsp_r_in     = spd_r_ff;
               rsp_dir_in   = held_dir_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      xneg_ff   <= xneg_in;
      full_ff   <= full_in;
      spd_l_ff  <= spd_l_in;
      spd_r_ff  <= spd_r_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rsp_l_ff  <= rsp_l_in;
      rsp_r_ff  <= rsp_r_in;
      rsp_dir_ff <= rsp_dir_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         dz_ff        <= DEADZONE_RESET;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         have_last_ff <= 1'b0;
         held_dir_ff  <= 1'b0;
         mcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dz_ff        <= dz_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         have_last_ff <= have_last_in;
         held_dir_ff  <= held_dir_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- arithmetic units ----
   jddm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_arg),
      .root     (sqrt_root),
      .status   (sqrt_st)
   );

   jddm_div #(
      .NUM_W (QW),
      .DEN_W (IN_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (div_num),
      .denom  (IN_W'(IN_FULL_SCALE)),
      .quot   (div_quot),
      .status (div_st)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed_left  = rsp_l_ff;
   assign rsp_speed_right = rsp_r_ff;
   assign rsp_dir_left    = rsp_dir_ff;
   assign rsp_dir_right   = rsp_dir_ff;

   // ---- assertions ----
   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !sqrt_st.busy && !div_st.busy)
      else $error("arithmetic unit busy while taking a sample");

   a_sqrt_done_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_st.done |-> state_ff == S_ROOT)
      else $error("square root finished outside its state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == S_DIV1 || state_ff == S_DIV2))
      else $error("divider finished outside a divide state");

   a_centered_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && changed && centered |=> state_ff == S_OUT)
      else $error("centered sample did not go straight to output");

endmodule

// ----- dv/joystick_differential_drive_mixer_top_test.sv -----
// Self-checking testbench for joystick_differential_drive_mixer_top: directed edge samples,
// deadzone register sweeps, backpressure and random traffic against an in-bench predictor.
// Depends on jddm_pkg and the block's top module only.
module joystick_differential_drive_mixer_top_test;
   import jddm_pkg::*;

   // Run limits
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 200;    // covers the worst-case sample latency
   localparam int HOLD_CYCLES   = 400;
   localparam logic [CSR_ADDR_W-1:0] DEADZONE_ADDR = {REG_DEADZONE, 2'b00};

   typedef struct packed {
      logic [SPEED_W-1:0] speed_left;
      logic [SPEED_W-1:0] speed_right;
      logic               dir_left;
      logic               dir_right;
   } drive_cmd_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready;
   logic signed [AXIS_W-1:0] req_stick_x, req_stick_y;
   logic rsp_valid, rsp_ready;
   logic [SPEED_W-1:0] rsp_speed_left, rsp_speed_right;
   logic rsp_dir_left, rsp_dir_right;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   // Mixer state as the predictor sees it
   logic signed [AXIS_W-1:0] prev_x, prev_y;
   bit                       seen_any;
   logic                     held_dir;
   logic [DZ_W-1:0]          dz_now;

   drive_cmd_type pending_cmds[$];
   int  errors = 0;
   int  cycle_count = 0;
   int  words_sent = 0;
   int  cmds_made = 0;
   int  cmds_checked = 0;
   int  dz_settings = 0;
   bit  idle_on = 1'b1;
   bit  hold_request = 1'b0;

   joystick_differential_drive_mixer_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_stick_x(req_stick_x), .req_stick_y(req_stick_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_speed_left(rsp_speed_left), .rsp_speed_right(rsp_speed_right),
      .rsp_dir_left(rsp_dir_left), .rsp_dir_right(rsp_dir_right),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Predict the drive command for one sample; returns 0 when the sample is a repeat
   function automatic bit mix_sample(input logic signed [AXIS_W-1:0] sx,
                                     input logic signed [AXIS_W-1:0] sy,
                                     output drive_cmd_type cmd);
      int ax, ay, root, full, in_spd, factor, left, right;
      cmd = '0;
      if (seen_any && sx == prev_x && sy == prev_y) return 1'b0;
      ax = (sx < 0) ? -int'(sx) : int'(sx);
      ay = (sy < 0) ? -int'(sy) : int'(sy);
      left = 0;
      right = 0;
      if (!(ax <= int'(dz_now) && ay <= int'(dz_now))) begin
         held_dir = (sy < 0);
         root = 0;
         while ((root + 1) * (root + 1) <= ax * ax + ay * ay) root++;
         full = root * OUT_FULL_SCALE_DEF / IN_FULL_SCALE_DEF;
         factor = (ax >= IN_FULL_SCALE_DEF) ? 0 : IN_FULL_SCALE_DEF - ax;
         in_spd = full * factor / IN_FULL_SCALE_DEF;
         // inside wheel is on the side x points to
         if (sx >= 0) begin
            left = full;
            right = in_spd;
         end else begin
            left = in_spd;
            right = full;
         end
      end
      prev_x = sx;
      prev_y = sy;
      seen_any = 1'b1;
      cmd.speed_left  = (left > int'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(left);
      cmd.speed_right = (right > int'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(right);
      cmd.dir_left  = held_dir;
      cmd.dir_right = held_dir;
      return 1'b1;
   endfunction

   // Offer one sample word and record its expected command on acceptance
   task automatic send_sample(input int vx, input int vy);
      int gap;
      drive_cmd_type cmd;
      logic signed [AXIS_W-1:0] sx, sy;
      sx  = AXIS_W'(vx);
      sy  = AXIS_W'(vy);
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_stick_x <= sx;
      req_stick_y <= sy;
      do @(posedge clock); while (!(req_valid && req_ready));
      words_sent++;
      if (mix_sample(sx, sy, cmd)) begin
         pending_cmds.push_back(cmd);
         cmds_made++;
      end
   endtask

   // Stop offering, wait for every command, then let the block go idle
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         $error("deadzone readback: expected %0d, got %0d", want, prdata);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Register writes happen only with the block idle
   task automatic set_deadzone(input int value);
      csr_write(DEADZONE_ADDR, CSR_DATA_W'(value));
      dz_now = DZ_W'(value);
      dz_settings++;
      csr_read_check(DEADZONE_ADDR, CSR_DATA_W'(value));
   endtask

   // Draw a sample: full-range noise, repeats, near-center, extremes, normal steering
   task automatic pick_sample(output logic signed [AXIS_W-1:0] sx,
                              output logic signed [AXIS_W-1:0] sy);
      int r, vx, vy;
      int corner[7] = '{-128, -100, -1, 0, 1, 100, 127};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            sx = AXIS_W'($urandom_range(0, 255));
            sy = AXIS_W'($urandom_range(0, 255));
         end
         4, 5: begin
            sx = prev_x;
            sy = prev_y;
         end
         6: begin
            r  = int'(dz_now) + 1;
            vx = $urandom_range(0, 2 * r) - r;
            vy = $urandom_range(0, 2 * r) - r;
            sx = AXIS_W'((vx > 127) ? 127 : vx);
            sy = AXIS_W'((vy > 127) ? 127 : vy);
         end
         7: begin
            sx = AXIS_W'(corner[$urandom_range(0, 6)]);
            sy = AXIS_W'(corner[$urandom_range(0, 6)]);
         end
         default: begin
            sx = AXIS_W'($urandom_range(0, 200) - 100);
            sy = AXIS_W'($urandom_range(0, 200) - 100);
         end
      endcase
   endtask

   // Send random samples until 'count' of them have produced a command
   task automatic run_random(input int count);
      int goal;
      logic signed [AXIS_W-1:0] sx, sy;
      goal = cmds_made + count;
      while (cmds_made < goal) begin
         pick_sample(sx, sy);
         send_sample(int'(sx), int'(sy));
      end
   endtask

   // Command receiver: random stalls per word, plus a long hold-off on request
   initial begin
      int gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         gap = idle_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Compare each accepted command word with the oldest expected one
   always @(posedge clock) begin
      drive_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            $error("unexpected command word: left %0d right %0d",
                   rsp_speed_left, rsp_speed_right);
            errors++;
         end else begin
            want = pending_cmds.pop_front();
            cmds_checked++;
            if (rsp_speed_left !== want.speed_left) begin
               $error("speed_left: expected %0d, got %0d", want.speed_left, rsp_speed_left);
               errors++;
            end
            if (rsp_speed_right !== want.speed_right) begin
               $error("speed_right: expected %0d, got %0d", want.speed_right,
                      rsp_speed_right);
               errors++;
            end
            if (rsp_dir_left !== want.dir_left) begin
               $error("dir_left: expected %0d, got %0d", want.dir_left, rsp_dir_left);
               errors++;
            end
            if (rsp_dir_right !== want.dir_right) begin
               $error("dir_right: expected %0d, got %0d", want.dir_right, rsp_dir_right);
               errors++;
            end
         end
      end
   end

   // Reset value of the deadzone register
   task automatic test_reset_defaults();
      csr_read_check(DEADZONE_ADDR, CSR_DATA_W'(DEADZONE_RESET));
   endtask

   // First sample, repeats, deadzone edge, held direction, full scale and beyond
   task automatic test_directed_edges();
      send_sample(0, 0);         // first sample always counts
      send_sample(0, 0);         // repeat: dropped
      send_sample(2, -2);        // on the deadzone edge, still centered
      send_sample(3, 0);         // just outside
      send_sample(0, 100);
      send_sample(0, -100);      // reverse
      send_sample(1, 1);         // centered keeps reverse
      send_sample(100, 0);       // inside wheel stops
      send_sample(-100, 0);
      send_sample(50, 50);
      send_sample(50, 50);
      send_sample(-50, 50);
      send_sample(50, -50);
      send_sample(-50, -50);
      send_sample(127, 127);     // beyond full scale
      send_sample(-128, -128);
      send_sample(-128, 127);
      send_sample(127, -128);
      send_sample(-128, 0);
      send_sample(0, -128);
      send_sample(99, 1);
      send_sample(-1, 0);
      send_sample(-101, 3);
      settle_block();
   endtask

   // Deadzone at zero, at the top of the 7-bit field and at full scale
   task automatic test_deadzone_extremes();
      set_deadzone(0);
      send_sample(0, 0);
      send_sample(1, 0);
      send_sample(0, -1);
      send_sample(0, 0);
      settle_block();
      set_deadzone(127);
      send_sample(127, -127);    // centered
      send_sample(-127, 127);
      send_sample(-128, 0);      // |x| = 128 is outside
      send_sample(0, -128);
      send_sample(5, 5);
      settle_block();
      set_deadzone(100);
      send_sample(100, -100);
      send_sample(101, 0);
      send_sample(-100, -101);
      settle_block();
   endtask

   // No idling on either side
   task automatic test_back_to_back();
      idle_on = 1'b0;
      set_deadzone(int'(DEADZONE_RESET));
      run_random(80);
      settle_block();
      idle_on = 1'b1;
   endtask

   // Long receiver hold-off while samples keep coming
   task automatic test_output_backpressure();
      int i;
      idle_on = 1'b0;
      hold_request = 1'b1;
      for (i = 0; i < 30; i++)
         send_sample(10 + 3 * i, -60 + 2 * i);
      idle_on = 1'b1;
      settle_block();
   endtask

   // Random traffic across several deadzone settings
   task automatic test_random_mix();
      int dz_list[6];
      int p;
      dz_list = '{2, 0, 100, 127, $urandom_range(0, 127), $urandom_range(0, 127)};
      for (p = 0; p < 6; p++) begin
         set_deadzone(dz_list[p]);
         run_random(150);
         settle_block();
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_stick_x <= '0;
      req_stick_y <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      prev_x   = '0;
      prev_y   = '0;
      seen_any = 1'b0;
      held_dir = 1'b0;
      dz_now   = DEADZONE_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_edges();
      test_deadzone_extremes();
      test_back_to_back();
      test_output_backpressure();
      test_random_mix();

      if (pending_cmds.size() != 0) begin
         $error("%0d expected command words never arrived", pending_cmds.size());
         errors++;
      end
      $display("Sent %0d sample words, checked %0d drive commands over %0d deadzone writes.",
               words_sent, cmds_checked, dz_settings);
      $display("Included repeats, centered sticks, over-range axes and a long output stall.");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- joystick_differential_drive_mixer_top.f -----
sv/jddm_pkg.sv
sv/jddm_isqrt.sv
sv/jddm_div.sv
sv/joystick_differential_drive_mixer_top.sv
dv/joystick_differential_drive_mixer_top_test.sv
